>>> rtl/chct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chct_pkg
// Types, constants and helper functions shared by the cell hit count table.
// ----------------------------------------------------------------------------
package chct_pkg;

    localparam int ID_W    = 64;
    localparam int CNT_W   = 32;
    localparam int LAYER_W = 32;
    localparam int CELLS_W = 9;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] LAYER_START_RST = 6'd0;
    localparam logic [CFG_W-1:0] LAYER_COUNT_RST = 6'd8;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [LAYER_W-1:0] layer;
        logic [CNT_W-1:0]   count;
    } t_mem_data;

    typedef struct packed {
        logic rd_en;
        logic wr_entry;
        logic wr_count;
    } t_mem_ctl;

    typedef struct packed {
        logic [CNT_W-1:0]   cell_hits;
        logic               new_cell;
        logic               table_full;
        logic [CELLS_W-1:0] layer_cells;
    } t_result;

    function automatic logic [LAYER_W-1:0] f_extract_layer(
        input logic [ID_W-1:0]  id,
        input logic [CFG_W-1:0] start,
        input logic [CFG_W-1:0] bits
    );
        logic [ID_W-1:0]    shifted;
        logic [LAYER_W-1:0] mask;
        shifted = id >> start;
        if (bits == '0) begin
            mask = '0;
        end else if (bits >= CFG_W'(LAYER_W)) begin
            mask = '1;
        end else begin
            mask = (LAYER_W'(1) << bits[4:0]) - LAYER_W'(1);
        end
        return shifted[LAYER_W-1:0] & mask;
    endfunction

endpackage
`default_nettype wire

>>> rtl/chct_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chct_in_if
// Input item channel: record or query op with valid/ready handshake.
// ----------------------------------------------------------------------------
interface chct_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [63:0] cell_id;
    logic        [31:0] layer_number;

    modport source (output valid, output op, output cell_id, output layer_number,
                    input ready);
    modport sink   (input valid, input op, input cell_id, input layer_number,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/chct_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chct_out_if
// Result item channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface chct_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] cell_hits;
    logic        new_cell;
    logic        table_full;
    logic [8:0]  layer_cells;

    modport source (output valid, output cell_hits, output new_cell,
                    output table_full, output layer_cells, input ready);
    modport sink   (input valid, input cell_hits, input new_cell,
                    input table_full, input layer_cells, output ready);
endinterface
`default_nettype wire

>>> rtl/cell_hit_count_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cell_hit_count_table
// Scan: a query, a new cell or a drop on a full table reads all N stored
//   entries; a record that hits entry k (from 0) ends the scan there. The
//   result is held in r_res and moves to the output register in S_DONE.
// Throughput: one item at a time; the scan streams one table read per cycle.
// Reset: entry count and config registers cleared to defaults; table contents
//   stay undefined and are only read below the entry count, so no clear pass.
// ----------------------------------------------------------------------------
module cell_hit_count_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [chct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [chct_pkg::CFG_W-1:0]     i_cfg_data,
    chct_in_if.sink                       i_in,
    chct_out_if.source                    o_out
);
    import chct_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    t_mem_ctl  mem_ctl;
    t_mem_data wr_data;
    t_mem_data rd_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    chct_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_mem_ctl  (mem_ctl),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .i_rd_data  (rd_data)
    );

    chct_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_mem_ctl (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule
`default_nettype wire

>>> rtl/chct_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chct_table
// Entry memory (cell ID and layer) and hit count memory, one read port and
// one write port each, registered read data.
// ----------------------------------------------------------------------------
module chct_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                          i_clk,
    input  chct_pkg::t_mem_ctl           i_mem_ctl,
    input  wire [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    input  wire [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  chct_pkg::t_mem_data          i_wr_data,
    output chct_pkg::t_mem_data          o_rd_data
);
    import chct_pkg::*;

    localparam int ENTRY_W = ID_W + LAYER_W;

    logic [ENTRY_W-1:0] r_entry_mem [TABLE_DEPTH];
    logic [CNT_W-1:0]   r_count_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_entry_rd;
    logic [CNT_W-1:0]   r_count_rd;

    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.wr_entry) begin
            r_entry_mem[i_wr_addr] <= {i_wr_data.id, i_wr_data.layer};
        end
        if (i_mem_ctl.rd_en) begin
            r_entry_rd <= r_entry_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.wr_count) begin
            r_count_mem[i_wr_addr] <= i_wr_data.count;
        end
        if (i_mem_ctl.rd_en) begin
            r_count_rd <= r_count_mem[i_rd_addr];
        end
    end

    assign o_rd_data.id    = r_entry_rd[ENTRY_W-1:LAYER_W];
    assign o_rd_data.layer = r_entry_rd[LAYER_W-1:0];
    assign o_rd_data.count = r_count_rd;

endmodule
`default_nettype wire

>>> rtl/chct_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chct_ctrl
// Scan sequencer: streams table reads, matches IDs or counts layers,
// writes back hit counts and appends new entries, holds config registers.
// ----------------------------------------------------------------------------
module chct_ctrl #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [chct_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [chct_pkg::CFG_W-1:0]          i_cfg_data,
    chct_in_if.sink                            i_in,
    chct_out_if.source                         o_out,
    output chct_pkg::t_mem_ctl                 o_mem_ctl,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_rd_addr,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_wr_addr,
    output chct_pkg::t_mem_data                o_wr_data,
    input  chct_pkg::t_mem_data                i_rd_data
);
    import chct_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0]      DEPTH_C   = CW'(TABLE_DEPTH);
    localparam logic [CELLS_W-1:0] CELLS_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic               r_op;
    logic [ID_W-1:0]    r_id;
    logic [LAYER_W-1:0] r_layer;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_idx;
    logic               r_pend;
    logic [AW-1:0]      r_pend_addr;
    logic [CW-1:0]      r_entry_count;
    logic [CFG_W-1:0]   r_cfg_start;
    logic [CFG_W-1:0]   r_cfg_bits;
    logic [CELLS_W-1:0] r_cells;
    t_result            r_res;
    logic               r_out_valid;
    t_result            r_out;

    logic             issue;
    logic             scan_end;
    logic             match;
    logic             append;
    logic             layer_hit;
    logic [CNT_W-1:0] inc_count;

    assign issue     = (r_state == S_SCAN) && (r_idx != r_n);
    assign scan_end  = (r_state == S_SCAN) && !r_pend && (r_idx == r_n);
    assign match     = (r_state == S_SCAN) && (r_op == OP_RECORD) && r_pend
                       && (i_rd_data.id == r_id);
    assign append    = scan_end && (r_op == OP_RECORD) && (r_n != DEPTH_C);
    assign layer_hit = r_pend && (i_rd_data.layer == r_layer);
    assign inc_count = (i_rd_data.count == '1) ? i_rd_data.count
                                               : i_rd_data.count + CNT_W'(1);

    assign o_mem_ctl.rd_en    = issue;
    assign o_mem_ctl.wr_entry = append;
    assign o_mem_ctl.wr_count = match || append;
    assign o_rd_addr          = r_idx[AW-1:0];
    assign o_wr_addr          = match ? r_pend_addr : r_n[AW-1:0];
    assign o_wr_data.id       = r_id;
    assign o_wr_data.layer    = f_extract_layer(r_id, r_cfg_start, r_cfg_bits);
    assign o_wr_data.count    = match ? inc_count : CNT_W'(1);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.cell_hits   = r_out.cell_hits;
    assign o_out.new_cell    = r_out.new_cell;
    assign o_out.table_full  = r_out.table_full;
    assign o_out.layer_cells = r_out.layer_cells;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_entry_count <= '0;
            r_cfg_start   <= LAYER_START_RST;
            r_cfg_bits    <= LAYER_COUNT_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LAYER_START: r_cfg_start <= i_cfg_data;
                    CFG_LAYER_COUNT: r_cfg_bits  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.op;
                        r_id    <= i_in.cell_id;
                        r_layer <= i_in.layer_number;
                        r_n     <= r_entry_count;
                        r_idx   <= '0;
                        r_cells <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_pend_addr <= r_idx[AW-1:0];
                        r_idx       <= r_idx + CW'(1);
                    end
                    if (r_op == OP_QUERY && layer_hit && r_cells != CELLS_MAX) begin
                        r_cells <= r_cells + CELLS_W'(1);
                    end
                    if (match) begin
                        r_res.cell_hits   <= inc_count;
                        r_res.new_cell    <= 1'b0;
                        r_res.table_full  <= 1'b0;
                        r_res.layer_cells <= '0;
                        r_state           <= S_DONE;
                    end else if (scan_end) begin
                        if (r_op == OP_QUERY) begin
                            r_res.cell_hits   <= '0;
                            r_res.new_cell    <= 1'b0;
                            r_res.table_full  <= 1'b0;
                            r_res.layer_cells <= r_cells;
                        end else if (append) begin
                            r_res.cell_hits   <= CNT_W'(1);
                            r_res.new_cell    <= 1'b1;
                            r_res.table_full  <= 1'b0;
                            r_res.layer_cells <= '0;
                            r_entry_count     <= r_n + CW'(1);
                        end else begin
                            r_res.cell_hits   <= '0;
                            r_res.new_cell    <= 1'b0;
                            r_res.table_full  <= 1'b1;
                            r_res.layer_cells <= '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
